### hw/rtl/pwcs_pkg.sv
// Package for the pulse tone channel: request codes, register addresses,
// the channel state record and the constant tables (length load, duty).
// Depends on nothing; used by pwcs_core and the top level.
package pwcs_pkg;

  // Kinds of request the channel takes.
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_QUARTER = 2'd2,
    OP_HALF    = 2'd3
  } op_t;

  // Register addresses for a write request.
  localparam logic [2:0] REG_ENV_DUTY = 3'd0;
  localparam logic [2:0] REG_SWEEP    = 3'd1;
  localparam logic [2:0] REG_PER_LO   = 3'd2;
  localparam logic [2:0] REG_PER_HI   = 3'd3;
  localparam logic [2:0] REG_ENABLE   = 3'd4;

  // Smallest period that still sounds.
  localparam logic [10:0] MIN_PERIOD = 11'd8;

  // Everything the channel remembers between requests.
  typedef struct packed {
    logic [3:0]        volume_setting;
    logic              constant_volume_flag;
    logic              loop_halt_flag;
    logic [1:0]        duty_select;
    logic [2:0]        sweep_reload;
    logic              sweep_decrease;
    logic [2:0]        sweep_shift;
    logic              sweep_enable;
    logic [10:0]       tone_period;
    logic [3:0]        current_volume;
    logic [3:0]        step_index;
    logic [7:0]        length_count;
    logic [4:0]        envelope_divider;
    logic [3:0]        envelope_level;
    logic [3:0]        sweep_divider;
    logic              channel_enabled;
    logic              channel_active;
    logic [11:0]       period_countdown;
    logic signed [6:0] output_level;
  } pwcs_state_t;

  // State after reset: all clear except the three dividers, which start at one.
  function automatic pwcs_state_t reset_state();
    pwcs_state_t s;
    begin
      s                  = '0;
      s.envelope_divider = 5'd1;
      s.sweep_divider    = 4'd1;
      s.period_countdown = 12'd1;
      return s;
    end
  endfunction

  // Length counter load values, indexed by the top five bits of the period high write.
  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    begin
      case (idx)
        5'd0:  val = 8'h0A;  5'd1:  val = 8'hFE;  5'd2:  val = 8'h14;  5'd3:  val = 8'h02;
        5'd4:  val = 8'h28;  5'd5:  val = 8'h04;  5'd6:  val = 8'h50;  5'd7:  val = 8'h06;
        5'd8:  val = 8'hA0;  5'd9:  val = 8'h08;  5'd10: val = 8'h3C;  5'd11: val = 8'h0A;
        5'd12: val = 8'h0E;  5'd13: val = 8'h0C;  5'd14: val = 8'h1A;  5'd15: val = 8'h0E;
        5'd16: val = 8'h0C;  5'd17: val = 8'h10;  5'd18: val = 8'h18;  5'd19: val = 8'h12;
        5'd20: val = 8'h30;  5'd21: val = 8'h14;  5'd22: val = 8'h60;  5'd23: val = 8'h16;
        5'd24: val = 8'hC0;  5'd25: val = 8'h18;  5'd26: val = 8'h48;  5'd27: val = 8'h1A;
        5'd28: val = 8'h10;  5'd29: val = 8'h1C;  5'd30: val = 8'h20;  5'd31: val = 8'h1E;
        default: val = 8'h00;
      endcase
      return val;
    end
  endfunction

  // Number of high steps out of sixteen for each duty setting.
  function automatic logic [3:0] duty_high_steps(input logic [1:0] duty);
    logic [3:0] val;
    begin
      case (duty)
        2'd0:    val = 4'd2;
        2'd1:    val = 4'd4;
        2'd2:    val = 4'd8;
        2'd3:    val = 4'd12;
        default: val = 4'd2;
      endcase
      return val;
    end
  endfunction

  // Output level: plus or minus four times the volume, by duty position.
  function automatic logic signed [6:0] wave_level(input logic [3:0] step,
                                                   input logic [1:0] duty,
                                                   input logic [3:0] vol);
    logic [6:0] mag;
    begin
      mag = {1'b0, vol, 2'b00};
      return (step < duty_high_steps(duty)) ? $signed(mag) : $signed(7'(-mag));
    end
  endfunction

endpackage

### hw/rtl/pwcs_core.sv
// Channel state and its combinational update for one accepted request.
// Depends on pwcs_pkg for the state record, codes and tables.
// Gives the level and active flag that hold after the request.
module pwcs_core
  import pwcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [2:0]        reg_index,
  input  logic [7:0]        write_data,
  input  logic              negate_twos,
  output logic signed [6:0] level_next,
  output logic              active_next
);

  pwcs_state_t st;
  pwcs_state_t st_next;

  // Next state for the request, followed by the activity check where it applies.
  always_comb begin
    logic        chk;
    logic [11:0] cd;
    logic [4:0]  ed;
    logic [3:0]  sd;
    logic [10:0] delta;
    logic [11:0] sum;
    logic        per_ok;
    st_next = st;
    chk     = 1'b0;
    cd      = st.period_countdown - 12'd1;
    ed      = st.envelope_divider - 5'd1;
    sd      = st.sweep_divider - 4'd1;
    delta   = st.tone_period >> st.sweep_shift;
    if (accept) begin
      case (op_t'(operation))
        OP_WRITE: begin
          chk = 1'b1;
          case (reg_index)
            REG_ENV_DUTY: begin
              st_next.volume_setting       = write_data[3:0];
              st_next.envelope_divider     = {1'b0, write_data[3:0]} + 5'd1;
              st_next.constant_volume_flag = write_data[4];
              st_next.loop_halt_flag       = write_data[5];
              st_next.duty_select          = write_data[7:6];
              st_next.current_volume       = write_data[4] ? write_data[3:0]
                                                           : st.envelope_level;
            end
            REG_SWEEP: begin
              st_next.sweep_shift    = write_data[2:0];
              st_next.sweep_decrease = write_data[3];
              st_next.sweep_reload   = write_data[6:4];
              st_next.sweep_enable   = write_data[7];
            end
            REG_PER_LO: begin
              st_next.tone_period = {st.tone_period[10:8], write_data};
            end
            REG_PER_HI: begin
              st_next.tone_period = {write_data[2:0], st.tone_period[7:0]};
              if (st.channel_enabled) begin
                st_next.length_count = length_lookup(write_data[7:3]);
              end
              st_next.envelope_level = 4'hF;
              st_next.step_index     = 4'd0;
            end
            REG_ENABLE: begin
              st_next.channel_enabled = |write_data;
              if (write_data == 8'd0) begin
                st_next.length_count = 8'd0;
              end
            end
            default: begin
            end
          endcase
        end
        OP_TICK: begin
          // The countdown reloads at zero and steps the duty sequencer.
          if (st.channel_active) begin
            if (cd == 12'd0) begin
              st_next.period_countdown = {1'b0, st.tone_period} + 12'd1;
              st_next.step_index       = st.step_index + 4'd1;
              st_next.output_level     = wave_level(st.step_index + 4'd1,
                                                    st.duty_select, st.current_volume);
            end else begin
              st_next.period_countdown = cd;
            end
          end
        end
        OP_QUARTER: begin
          // Envelope divider; on expiry the level decays or loops.
          if (st.channel_active) begin
            if (ed == 5'd0) begin
              st_next.envelope_divider = {1'b0, st.volume_setting} + 5'd1;
              if (st.envelope_level != 4'd0) begin
                st_next.envelope_level = st.envelope_level - 4'd1;
              end else begin
                st_next.envelope_level = st.loop_halt_flag ? 4'hF : 4'd0;
              end
              st_next.current_volume = st.constant_volume_flag ? st.volume_setting
                                                               : st_next.envelope_level;
            end else begin
              st_next.envelope_divider = ed;
            end
          end
        end
        OP_HALF: begin
          chk = 1'b1;
          // Sweep divider; on expiry the period moves by the shifted amount.
          if (st.channel_active && st.sweep_enable) begin
            if (sd == 4'd0) begin
              st_next.sweep_divider = {1'b0, st.sweep_reload} + 4'd1;
              if (st.sweep_shift != 3'd0) begin
                if (!st.sweep_decrease) begin
                  st_next.tone_period = st.tone_period + delta;
                end else begin
                  st_next.tone_period = st.tone_period - delta - {10'd0, ~negate_twos};
                end
              end
            end else begin
              st_next.sweep_divider = sd;
            end
          end
          // Length counter runs down unless halted.
          if (st.channel_active && !st.loop_halt_flag && st.length_count != 8'd0) begin
            st_next.length_count = st.length_count - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
    // Activity check on the updated period, enable and length.
    sum    = {1'b0, st_next.tone_period} + {1'b0, st_next.tone_period >> st_next.sweep_shift};
    per_ok = (st_next.tone_period >= MIN_PERIOD) && (st_next.sweep_decrease || !sum[11]);
    if (chk) begin
      st_next.channel_active = per_ok && st_next.channel_enabled
                               && (st_next.length_count != 8'd0);
      st_next.output_level   = st_next.channel_active
                               ? wave_level(st_next.step_index, st_next.duty_select,
                                            st_next.current_volume)
                               : 7'sd0;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
    end else begin
      st <= st_next;
    end
  end

  assign level_next  = st_next.output_level;
  assign active_next = st_next.channel_active;

endmodule

### hw/rtl/pulse_wave_channel_with_sweep_unit.sv
// Top level of the pulse tone channel: request handshake, sweep negation
// register and a two-entry result buffer around pwcs_core.
// Depends on pwcs_pkg and pwcs_core.

// The channel takes one request (register write, timer tick, quarter-frame or
// half-frame clock) in every cycle in which in_stall is low and returns exactly
// one result for each from a registered output: the signed output level and the
// active flag as they stand after that request. The whole channel update is
// combinational between the state registers and a result register;
// a second result slot absorbs a stall on the output, and in_stall rises only
// while both slots are full. The sweep negation mode (ones' or two's
// complement) is set through the configuration write port; the user must write
// it only while the channel is idle, which the block itself does not enforce.
module pulse_wave_channel_with_sweep_unit
  import pwcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic              cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        operation,
  input  logic [2:0]        reg_index,
  input  logic [7:0]        write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [6:0] level,
  output logic              active
);

  logic              sweep_negate_twos;
  logic              in_accept;
  logic              out_take;
  logic signed [6:0] level_next;
  logic              active_next;
  logic              skid_valid;
  logic signed [6:0] skid_level;
  logic              skid_active;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_negate_twos <= 1'b0;
    end else if (cfg_write_enable) begin
      sweep_negate_twos <= cfg_write_data;
    end
  end

  pwcs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .operation   (operation),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .negate_twos (sweep_negate_twos),
    .level_next  (level_next),
    .active_next (active_next)
  );

  // Result register with a skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload follows the same choice as the valid bits.
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        level  <= skid_level;
        active <= skid_active;
      end else if (in_accept) begin
        level  <= level_next;
        active <= active_next;
      end
    end else if (in_accept) begin
      skid_level  <= level_next;
      skid_active <= active_next;
    end
  end

endmodule

### test/tb_pulse_wave_channel_with_sweep_unit.sv
// Self-checking testbench for the pulse tone channel: directed and random requests
// with random stalls on both sides, checked against a behavioural channel predictor.
// Depends on pwcs_pkg and the pulse_wave_channel_with_sweep_unit RTL.
module tb_pulse_wave_channel_with_sweep_unit;
  import pwcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT = 2000;
  // Register addresses that the channel does not decode.
  localparam logic [2:0]  REG_NONE_LO = 3'd5;
  localparam logic [2:0]  REG_NONE_HI = 3'd7;

  localparam logic [7:0] LENGTH_LOAD [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };
  localparam logic [3:0] DUTY_HIGH [4] = '{4'd2, 4'd4, 4'd8, 4'd12};

  typedef struct packed {
    logic signed [6:0] lvl;
    logic              act;
  } chan_out_t;

  typedef struct packed {
    op_t               op;
    logic [2:0]        addr;
    logic [7:0]        data;
    logic              typed;
    logic signed [6:0] lvl;
    logic              act;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write_enable;
  logic              cfg_write_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        operation;
  logic [2:0]        reg_index;
  logic [7:0]        write_data;
  logic              out_valid;
  logic              out_stall;
  logic signed [6:0] level;
  logic              active;

  // Handshake and outputs as they stood just before each rising edge.
  logic              rst_s = 1'b1;
  logic              in_fire = 1'b0;
  logic              out_fire = 1'b0;
  logic signed [6:0] level_s = '0;
  logic              active_s = 1'b0;

  bit                idling_on = 1'b1;
  int                mismatches = 0;
  int                quiet_cycles = 0;
  chan_out_t         levels_due[$];

  // Predicted channel state.
  logic              twos_negate;
  logic [3:0]        env_vol, cur_vol, env_lvl, step, sw_div;
  logic              const_vol, halt, sw_down, sw_on, enabled, sounding;
  logic [1:0]        duty;
  logic [2:0]        sw_reload, sw_shift;
  logic [10:0]       period;
  logic [7:0]        len_cnt;
  logic [4:0]        env_div;
  logic [11:0]       countdown;
  logic signed [6:0] out_lvl;

  // Directed requests: register extremes, every request kind and the corner cases.
  directed_row_t script [23] = '{
    '{OP_TICK,    REG_ENV_DUTY, 8'h00, 1'b1, 7'sd0,  1'b0},
    '{OP_QUARTER, REG_ENV_DUTY, 8'h00, 1'b1, 7'sd0,  1'b0},
    '{OP_HALF,    REG_ENV_DUTY, 8'h00, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_NONE_LO,  8'hFF, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_PER_HI,   8'hF8, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_ENABLE,   8'h80, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_ENV_DUTY, 8'hFF, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_PER_LO,   8'h08, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_PER_HI,   8'h08, 1'b1, 7'sd60, 1'b1},
    '{OP_TICK,    REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_TICK,    REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_TICK,    REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_TICK,    REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_QUARTER, REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_QUARTER, REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_SWEEP,    8'hFF, 1'b0, 7'sd0,  1'b0},
    '{OP_HALF,    REG_ENV_DUTY, 8'h00, 1'b0, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_SWEEP,    8'h81, 1'b0, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_PER_LO,   8'hFF, 1'b0, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_PER_HI,   8'h07, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_NONE_HI,  8'h00, 1'b1, 7'sd0,  1'b0},
    '{OP_WRITE,   REG_ENABLE,   8'h00, 1'b1, 7'sd0,  1'b0}
  };

  pulse_wave_channel_with_sweep_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .reg_index        (reg_index),
    .write_data       (write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .level            (level),
    .active           (active)
  );

  always #2 clk = ~clk;

  // All inputs change at the rising edge, so the falling edge sees settled values.
  always @(negedge clk) begin
    rst_s    <= rst;
    in_fire  <= in_valid && !in_stall;
    out_fire <= out_valid && !out_stall;
    level_s  <= level;
    active_s <= active;
  end

  // Signed sample of the duty sequence at the current step and volume.
  function automatic logic signed [6:0] duty_sample();
    int sign;
    sign = (step < DUTY_HIGH[duty]) ? 4 : -4;
    return 7'(sign * int'(cur_vol));
  endfunction

  // The channel sounds when enabled, with length left and a period that a sweep keeps in range.
  function automatic void check_sounding();
    logic [11:0] raised;
    logic        ok;
    raised   = {1'b0, period} + {1'b0, period >> sw_shift};
    ok       = (period >= MIN_PERIOD) && (sw_down || !raised[11]);
    sounding = ok && enabled && (len_cnt != 8'd0);
    out_lvl  = sounding ? duty_sample() : 7'sd0;
  endfunction

  function automatic void clear_channel();
    twos_negate = 1'b0;
    env_vol = '0; const_vol = 1'b0; halt = 1'b0; duty = '0;
    sw_reload = '0; sw_down = 1'b0; sw_shift = '0; sw_on = 1'b0;
    period = '0; cur_vol = '0; step = '0; len_cnt = '0;
    env_div = 5'd1; env_lvl = '0; sw_div = 4'd1;
    enabled = 1'b0; sounding = 1'b0; countdown = 12'd1; out_lvl = '0;
  endfunction

  // Moves the predicted channel through one request and returns the output it leaves.
  function automatic chan_out_t advance_channel(input op_t op, input logic [2:0] addr,
                                                input logic [7:0] data);
    logic [10:0] delta;
    chan_out_t   res;
    case (op)
      OP_WRITE: begin
        case (addr)
          REG_ENV_DUTY: begin
            env_vol   = data[3:0];
            env_div   = {1'b0, data[3:0]} + 5'd1;
            const_vol = data[4];
            halt      = data[5];
            duty      = data[7:6];
            cur_vol   = const_vol ? env_vol : env_lvl;
          end
          REG_SWEEP: begin
            sw_shift  = data[2:0];
            sw_down   = data[3];
            sw_reload = data[6:4];
            sw_on     = data[7];
          end
          REG_PER_LO: period[7:0] = data;
          REG_PER_HI: begin
            period[10:8] = data[2:0];
            // The length only loads while the channel is enabled.
            if (enabled) len_cnt = LENGTH_LOAD[data[7:3]];
            env_lvl = 4'hF;
            step    = '0;
          end
          REG_ENABLE: begin
            enabled = (data != 8'd0);
            if (!enabled) len_cnt = '0;
          end
          default: ;
        endcase
        check_sounding();
      end
      OP_TICK: if (sounding) begin
        countdown = countdown - 12'd1;
        if (countdown == 12'd0) begin
          countdown = {1'b0, period} + 12'd1;
          step      = step + 4'd1;
          out_lvl   = duty_sample();
        end
      end
      OP_QUARTER: if (sounding) begin
        env_div = env_div - 5'd1;
        if (env_div == 5'd0) begin
          env_div = {1'b0, env_vol} + 5'd1;
          if (env_lvl != 4'd0) env_lvl = env_lvl - 4'd1;
          else env_lvl = halt ? 4'hF : 4'h0;
          cur_vol = const_vol ? env_vol : env_lvl;
        end
      end
      OP_HALF: begin
        if (sounding && sw_on) begin
          sw_div = sw_div - 4'd1;
          if (sw_div == 4'd0) begin
            sw_div = {1'b0, sw_reload} + 4'd1;
            if (sw_shift != 3'd0) begin
              delta = period >> sw_shift;
              if (!sw_down) period = period + delta;
              else if (twos_negate) period = period - delta;
              else period = period - delta - 11'd1;
            end
          end
        end
        if (sounding && !halt && len_cnt != 8'd0) len_cnt = len_cnt - 8'd1;
        check_sounding();
      end
      default: ;
    endcase
    res.lvl = out_lvl;
    res.act = sounding;
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %0s", msg);
  endtask

  // Compare each returned result with the oldest outstanding prediction.
  always @(posedge clk) begin
    chan_out_t want;
    if (!rst_s && out_fire) begin
      if (levels_due.size() == 0) begin
        log_mismatch($sformatf("result with no request outstanding, level %0d active %0b",
                               level_s, active_s));
      end else begin
        want = levels_due.pop_front();
        if (want.lvl !== level_s)
          log_mismatch($sformatf("level expected %0d, got %0d", want.lvl, level_s));
        if (want.act !== active_s)
          log_mismatch($sformatf("active expected %0b, got %0b", want.act, active_s));
      end
    end
  end

  // Count cycles in which neither side moves a request or a result.
  always @(posedge clk) begin
    if (rst_s || in_fire || out_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: stall in random bursts while idling is on.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offers one request, waits for it to be taken and records the output it should give.
  task automatic send_request(input op_t op, input logic [2:0] addr, input logic [7:0] data,
                              input logic typed, input chan_out_t typed_out);
    chan_out_t predicted;
    in_valid   <= 1'b1;
    operation  <= op;
    reg_index  <= addr;
    write_data <= data;
    do @(posedge clk); while (!in_fire);
    predicted = advance_channel(op, addr, data);
    levels_due.push_back(typed ? typed_out : predicted);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain_channel();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_sweep_mode(input logic twos);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= twos;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    twos_negate = twos;
  endtask

  // Random request, weighted towards timer ticks with plausible register contents.
  task automatic pick_request(output op_t op, output logic [2:0] addr, output logic [7:0] data);
    int r;
    r    = $urandom_range(0, 99);
    addr = REG_ENV_DUTY;
    data = 8'($urandom_range(0, 255));
    if (r < 14) begin
      op = OP_WRITE;
      case ($urandom_range(0, 15))
        0, 1, 2:   addr = REG_ENV_DUTY;
        3, 4, 5:   addr = REG_SWEEP;
        6, 7, 8: begin
          addr = REG_PER_LO;
          if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 40));
        end
        9, 10, 11: begin
          addr = REG_PER_HI;
          if ($urandom_range(0, 5) != 0) data[2:0] = 3'b000;
        end
        12, 13: begin
          addr = REG_ENABLE;
          data = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        end
        default: addr = 3'($urandom_range(REG_NONE_LO, REG_NONE_HI));
      endcase
    end else if (r < 70) begin
      op = OP_TICK;
    end else if (r < 85) begin
      op = OP_QUARTER;
    end else begin
      op = OP_HALF;
    end
  endtask

  // Random requests until the given number have been sent.
  task automatic random_phase(input int target);
    int         done;
    op_t        op;
    logic [2:0] addr;
    logic [7:0] data;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 39) == 0) begin
        // Full set-up so that the channel sounds with fresh random settings.
        send_request(OP_WRITE, REG_ENABLE, 8'($urandom_range(1, 255)), 1'b0, '0);
        send_request(OP_WRITE, REG_ENV_DUTY, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_request(OP_WRITE, REG_SWEEP, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_request(OP_WRITE, REG_PER_LO, 8'($urandom_range(8, 40)), 1'b0, '0);
        send_request(OP_WRITE, REG_PER_HI, {5'($urandom_range(0, 31)), 3'b000}, 1'b0, '0);
        done += 5;
      end else begin
        pick_request(op, addr, data);
        done++;
        send_request(op, addr, data, 1'b0, '0);
      end
    end
  endtask

  // Main sequence: reset, directed table, then random phases under both sweep modes.
  initial begin
    int        i;
    chan_out_t typed_out;
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    operation        <= OP_WRITE;
    reg_index        <= REG_ENV_DUTY;
    write_data       <= 8'd0;
    cfg_write_enable <= 1'b0;
    cfg_write_data   <= 1'b0;
    clear_channel();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_sweep_mode(1'b0);

    for (i = 0; i < $size(script); i++) begin
      typed_out.lvl = script[i].lvl;
      typed_out.act = script[i].act;
      send_request(script[i].op, script[i].addr, script[i].data, script[i].typed, typed_out);
    end

    random_phase(200);
    drain_channel();
    random_phase(200);
    drain_channel();
    set_sweep_mode(1'b1);
    random_phase(400);
    drain_channel();
    set_sweep_mode(1'b0);
    idling_on = 1'b0;
    random_phase(400);
    drain_channel();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pwcs_pkg.sv
hw/rtl/pwcs_core.sv
hw/rtl/pulse_wave_channel_with_sweep_unit.sv
test/tb_pulse_wave_channel_with_sweep_unit.sv
